// ===== sv/bdm_pkg.sv =====
// Shared constants, types and helpers for the multi-press button debouncer.
package bdm_pkg;

    localparam int NUM_BUTTONS = 2;
    localparam int MAX_BUTTONS = 4;
    localparam int CNT_W       = 4;
    localparam int RUN_W       = 16;
    localparam int PADDR_W     = 4;

    typedef logic [RUN_W-1:0] t_run;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [1:0]       t_stage;
    typedef logic [1:0]       t_reg_idx;

    localparam t_stage STAGE_IDLE  = 2'd0;
    localparam t_stage STAGE_FIRST = 2'd1;
    localparam t_stage STAGE_WAIT  = 2'd2;

    localparam t_reg_idx REG_DEBOUNCE = 2'd0;
    localparam t_reg_idx REG_GAP      = 2'd1;
    localparam t_reg_idx REG_MAX      = 2'd2;

    localparam t_run DEBOUNCE_RST = 16'd200;
    localparam t_run GAP_RST      = 16'd5000;
    localparam t_run MAX_RST      = 16'd35;

    localparam t_run RUN_MAX = '1;
    localparam t_cnt CNT_MAX = '1;

    function automatic t_run sat_inc(input t_run v);
        sat_inc = (v == RUN_MAX) ? v : v + t_run'(1);
    endfunction

endpackage

// ===== sv/button_debounce_multipress.sv =====
// Multi-press button debouncer: per-button press-series counting with APB setup.
// An accepted request's result is captured in the output register. Throughput:
// one request per cycle while i_out_ready is high; the per-button update is a
// single pass of counters and compares between the state and result registers.
// Reset (synchronous, active low) clears all button state and the output valid,
// and loads debounce 200, gap timeout 5000, max-press limits 3 and 2 (packed 35).
module button_debounce_multipress
    import bdm_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [3:0]                      i_pressed_levels,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [4*CNT_W-1:0]              o_press_counts,
    output logic [3:0]                      o_series_done_mask,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [PADDR_W-1:0]              paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    t_run r_debounce;
    t_run r_gap_to;
    t_run r_max_packed;

    t_run   r_prun [NUM_BUTTONS];
    t_run   r_rrun [NUM_BUTTONS];
    t_stage r_stage[NUM_BUTTONS];
    logic   r_flag [NUM_BUTTONS];
    t_run   r_gap  [NUM_BUTTONS];
    t_cnt   r_car  [NUM_BUTTONS];
    t_cnt   r_cnt  [NUM_BUTTONS];
    logic   r_done [NUM_BUTTONS];

    t_run   n_prun [NUM_BUTTONS];
    t_run   n_rrun [NUM_BUTTONS];
    t_stage n_stage[NUM_BUTTONS];
    logic   n_flag [NUM_BUTTONS];
    t_run   n_gap  [NUM_BUTTONS];
    t_cnt   n_car  [NUM_BUTTONS];
    t_cnt   n_cnt  [NUM_BUTTONS];
    logic   n_done [NUM_BUTTONS];
    t_cnt   lim    [NUM_BUTTONS];

    logic [4*CNT_W-1:0] n_counts;
    logic [3:0]         n_mask;
    logic               r_out_valid;
    logic               in_fire;
    logic               cfg_wr;
    t_reg_idx           reg_idx;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign reg_idx     = paddr[3:2];

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_gap_to     <= GAP_RST;
            r_max_packed <= MAX_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEBOUNCE: r_debounce   <= pwdata[RUN_W-1:0];
                REG_GAP:      r_gap_to     <= pwdata[RUN_W-1:0];
                REG_MAX:      r_max_packed <= pwdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DEBOUNCE: prdata = {16'd0, r_debounce};
            REG_GAP:      prdata = {16'd0, r_gap_to};
            REG_MAX:      prdata = {16'd0, r_max_packed};
            default:      prdata = '0;
        endcase
    end

    // per-button update, once per accepted request
    always_comb begin
        n_counts = '0;
        n_mask   = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            n_prun[b]  = r_prun[b];
            n_rrun[b]  = r_rrun[b];
            n_stage[b] = r_stage[b];
            n_flag[b]  = r_flag[b];
            n_gap[b]   = r_gap[b];
            n_car[b]   = r_car[b];
            n_cnt[b]   = r_cnt[b];
            n_done[b]  = r_done[b];
            lim[b]     = r_max_packed[4*b +: 4];

            // gap timer runs before the level is looked at
            if (n_stage[b] == STAGE_WAIT) begin
                n_gap[b] = sat_inc(r_gap[b]);
                if (n_gap[b] >= r_gap_to) begin
                    if (r_cnt[b] != '0) n_done[b] = 1'b1;
                    n_gap[b]   = '0;
                    n_stage[b] = STAGE_IDLE;
                end
            end

            if (i_pressed_levels[b]) begin
                n_prun[b] = sat_inc(r_prun[b]);
                n_rrun[b] = '0;
                if (n_prun[b] >= r_debounce) begin
                    if (n_stage[b] == STAGE_WAIT) begin
                        if (r_cnt[b] < lim[b])
                            n_cnt[b] = (r_car[b] == CNT_MAX) ? CNT_MAX : r_car[b] + t_cnt'(1);
                        n_flag[b] = 1'b1;
                        n_done[b] = 1'b0;
                    end else begin
                        if (!r_flag[b]) begin
                            n_cnt[b]  = t_cnt'(1);
                            n_done[b] = 1'b0;
                        end
                        if (n_stage[b] == STAGE_IDLE) n_stage[b] = STAGE_FIRST;
                    end
                end
            end else begin
                n_rrun[b] = sat_inc(r_rrun[b]);
                n_prun[b] = '0;
                if (n_rrun[b] >= r_debounce &&
                    (n_stage[b] == STAGE_FIRST || r_flag[b])) begin
                    n_stage[b] = STAGE_WAIT;
                    n_gap[b]   = '0;
                    n_car[b]   = r_cnt[b];
                    n_flag[b]  = 1'b0;
                end
            end

            n_counts[4*b +: 4] = n_cnt[b];
            n_mask[b]          = n_done[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_prun[b]  <= '0;
                r_rrun[b]  <= '0;
                r_stage[b] <= STAGE_IDLE;
                r_flag[b]  <= 1'b0;
                r_gap[b]   <= '0;
                r_car[b]   <= '0;
                r_cnt[b]   <= '0;
                r_done[b]  <= 1'b0;
            end
        end else if (in_fire) begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_prun[b]  <= n_prun[b];
                r_rrun[b]  <= n_rrun[b];
                r_stage[b] <= n_stage[b];
                r_flag[b]  <= n_flag[b];
                r_gap[b]   <= n_gap[b];
                r_car[b]   <= n_car[b];
                r_cnt[b]   <= n_cnt[b];
                r_done[b]  <= n_done[b];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            o_press_counts     <= n_counts;
            o_series_done_mask <= n_mask;
        end
    end

endmodule
